@@ hw/rtl/tdt_pkg.sv @@
`default_nettype none

package tdt_pkg;

   // Field widths
   localparam int TIME_W = 32;
   localparam int SLOT_W = 4;
   localparam int CMD_W  = 2;
   localparam int MODE_W = 2;

   // Slot count default and result limit per tick
   localparam int DEF_NUM_SLOTS = 16;
   localparam int MAX_RESULTS   = 16;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOAD     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SET_NEXT = 2'd2;

   // Set-next modes
   localparam logic [MODE_W-1:0] MODE_NOW    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_NEVER  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_OFFSET = 2'd2;

   // Special values
   localparam logic [TIME_W-1:0] NEVER_TIME = 32'hFFFF_FFFF;
   localparam logic [TIME_W-1:0] UNLIMITED  = 32'hFFFF_FFFF;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic set_next;
      logic start;
      logic issue;
      logic step;
      logic kill;
      logic flush;
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic last_addr;
      logic eval_valid;
      logic eval_fire;
      logic pend_valid;
      logic out_free;
      logic limit_next;
   } dp_sts_type;

endpackage

`default_nettype wire

@@ hw/rtl/tdt_if.sv @@
`default_nettype none

interface tdt_req_if;
   import tdt_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [CMD_W-1:0]         command;
   logic [TIME_W-1:0]        now;
   logic [SLOT_W-1:0]        slot;
   logic                     task_active;
   logic [MODE_W-1:0]        next_mode;
   logic [TIME_W-1:0]        next_value;
   logic [TIME_W-1:0]        period;
   logic signed [TIME_W-1:0] iterations;

   modport source (output valid, command, now, slot, task_active, next_mode, next_value,
                   period, iterations, input ready);
   modport sink (input valid, command, now, slot, task_active, next_mode, next_value,
                 period, iterations, output ready);
endinterface

interface tdt_rsp_if;
   import tdt_pkg::*;

   logic              valid;
   logic              ready;
   logic              fired;
   logic [SLOT_W-1:0] task_slot;
   logic              last;

   modport source (output valid, fired, task_slot, last, input ready);
   modport sink (input valid, fired, task_slot, last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/periodic_task_dispatch_timer.sv @@
// Load and set-next are written at their transfer, and the block stays ready to take the next item.
// A tick scans one slot per cycle through the slot RAMs (read, then evaluate and write back)
// unless a dispatch waits on a stalled output; it ends early once MAX_RESULTS slots have
// fired. The next item can be taken in the same cycle that the last result is presented,
// even while that result still waits.
// Reset is synchronous: slot flags and per-entry valid bits clear at once, so every slot
// reads as inactive, never due, period zero and unlimited count; there is no clearing pass.
`default_nettype none

module periodic_task_dispatch_timer
   import tdt_pkg::*;
#(
   parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
   input wire logic  clock,
   input wire logic  reset,
   tdt_req_if.sink   req_chan,
   tdt_rsp_if.source rsp_chan
);

   ctl_cmd_type cmd;
   dp_sts_type  sts;

   tdt_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_ready   (req_chan.ready),
      .sts         (sts),
      .cmd         (cmd)
   );

   tdt_dpath #(.NUM_SLOTS(NUM_SLOTS)) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_now         (req_chan.now),
      .req_slot        (req_chan.slot),
      .req_task_active (req_chan.task_active),
      .req_next_mode   (req_chan.next_mode),
      .req_next_value  (req_chan.next_value),
      .req_period      (req_chan.period),
      .req_iterations  (req_chan.iterations),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_fired       (rsp_chan.fired),
      .rsp_task_slot   (rsp_chan.task_slot),
      .rsp_last        (rsp_chan.last)
   );

endmodule

`default_nettype wire

@@ hw/rtl/tdt_ram.sv @@
`default_nettype none

module tdt_ram
   import tdt_pkg::*;
#(
   parameter int WIDTH = TIME_W,
   parameter int DEPTH = DEF_NUM_SLOTS
) (
   input  wire logic                                   clock,
   input  wire logic                                   we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]                       wdata,
   input  wire logic                                   re,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic      [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

@@ hw/rtl/tdt_ctrl.sv @@
`default_nettype none

module tdt_ctrl
   import tdt_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic [CMD_W-1:0] req_command,
   output logic                  req_ready,
   input  wire dp_sts_type       sts,
   output ctl_cmd_type           cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_FLUSH = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       more_ff, more_in;
   logic       stall;
   logic       limit;

   // Sequence commands, scan and final result
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      more_in   = more_ff;
      req_ready = 1'b0;
      stall     = sts.eval_valid && sts.eval_fire && sts.pend_valid && !sts.out_free;
      limit     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (req_command)
                  CMD_LOAD:     cmd.load = 1'b1;
                  CMD_SET_NEXT: cmd.set_next = 1'b1;
                  CMD_TICK: begin
                     cmd.start = 1'b1;
                     more_in   = 1'b1;
                     state_in  = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            cmd.step  = sts.eval_valid && !stall;
            limit     = cmd.step && sts.limit_next;
            cmd.issue = !stall && more_ff && !limit;
            if (cmd.issue && sts.last_addr) begin
               more_in = 1'b0;
            end
            if (limit) begin
               cmd.kill = 1'b1;
               more_in  = 1'b0;
               state_in = ST_FLUSH;
            end else if (!more_ff && (!sts.eval_valid || cmd.step)) begin
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            if (sts.out_free) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         more_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         more_ff  <= more_in;
      end
   end

endmodule

`default_nettype wire

@@ hw/rtl/tdt_dpath.sv @@
`default_nettype none

module tdt_dpath
   import tdt_pkg::*;
#(
   parameter int NUM_SLOTS = DEF_NUM_SLOTS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ctl_cmd_type              cmd,
   output dp_sts_type                    sts,
   input  wire logic [TIME_W-1:0]        req_now,
   input  wire logic [SLOT_W-1:0]        req_slot,
   input  wire logic                     req_task_active,
   input  wire logic [MODE_W-1:0]        req_next_mode,
   input  wire logic [TIME_W-1:0]        req_next_value,
   input  wire logic [TIME_W-1:0]        req_period,
   input  wire logic signed [TIME_W-1:0] req_iterations,
   input  wire logic                     rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_fired,
   output logic [SLOT_W-1:0]             rsp_task_slot,
   output logic                          rsp_last
);

   localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W = $clog2(MAX_RESULTS + 1);

   logic [TIME_W-1:0]    now_ff, now_in;
   logic [IDX_W-1:0]     rd_addr_ff, rd_addr_in;
   logic [IDX_W-1:0]     eval_idx_ff, eval_idx_in;
   logic                 eval_valid_ff, eval_valid_in;
   logic [NUM_SLOTS-1:0] active_ff, active_in;
   logic [NUM_SLOTS-1:0] nd_vld_ff, nd_vld_in;
   logic [NUM_SLOTS-1:0] per_vld_ff, per_vld_in;
   logic [NUM_SLOTS-1:0] rem_vld_ff, rem_vld_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]     pend_slot_ff, pend_slot_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_fired_ff, rsp_fired_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic                 slot_ok;
   logic [IDX_W-1:0]     slot_idx;
   logic                 load_ok;
   logic                 setnext_ok;
   logic [TIME_W-1:0]    setnext_val;

   logic [TIME_W-1:0]    nd_rdata, per_rdata, rem_rdata;
   logic [TIME_W-1:0]    cur_nd, cur_per, cur_rem;
   logic                 cur_act;
   logic                 armed, exhausted, fire;
   logic [TIME_W-1:0]    diff;
   logic [TIME_W-1:0]    new_nd, new_rem;
   logic                 scan_we;
   logic                 push_pend;

   logic                 nd_we, per_we, rem_we;
   logic [IDX_W-1:0]     wr_addr;
   logic [TIME_W-1:0]    nd_wdata, rem_wdata;

   // Decode load and set-next
   always_comb begin
      slot_ok     = 32'(req_slot) < 32'(NUM_SLOTS);
      slot_idx    = IDX_W'(req_slot);
      load_ok     = cmd.load && slot_ok;
      setnext_ok  = 1'b0;
      setnext_val = NEVER_TIME;
      case (req_next_mode)
         MODE_NOW: begin
            setnext_ok  = cmd.set_next && slot_ok;
            setnext_val = req_now;
         end
         MODE_NEVER: begin
            setnext_ok  = cmd.set_next && slot_ok;
            setnext_val = NEVER_TIME;
         end
         MODE_OFFSET: begin
            setnext_ok  = cmd.set_next && slot_ok;
            setnext_val = (req_next_value == NEVER_TIME) ? NEVER_TIME
                                                         : req_now + req_next_value;
         end
         default: ;
      endcase
   end

   // Evaluate the slot whose entries the RAMs present
   always_comb begin
      cur_nd    = nd_vld_ff[eval_idx_ff] ? nd_rdata : NEVER_TIME;
      cur_per   = per_vld_ff[eval_idx_ff] ? per_rdata : '0;
      cur_rem   = rem_vld_ff[eval_idx_ff] ? rem_rdata : UNLIMITED;
      cur_act   = active_ff[eval_idx_ff];
      armed     = cur_act && (cur_nd != NEVER_TIME);
      exhausted = armed && (cur_rem == '0);
      diff      = cur_nd - now_ff;
      fire      = armed && !exhausted && ((diff == '0) || diff[TIME_W-1]);
      if (exhausted) begin
         new_nd  = NEVER_TIME;
         new_rem = UNLIMITED;
      end else begin
         new_nd  = (cur_per == '0) ? NEVER_TIME : cur_nd + cur_per;
         new_rem = (!cur_rem[TIME_W-1] && (cur_rem != '0)) ? cur_rem - 1'b1 : cur_rem;
      end
      scan_we   = cmd.step && (exhausted || fire);
      push_pend = cmd.step && fire && pend_valid_ff;
   end

   // Select RAM writes
   always_comb begin
      nd_we     = load_ok || setnext_ok || scan_we;
      per_we    = load_ok;
      rem_we    = load_ok || scan_we;
      wr_addr   = scan_we ? eval_idx_ff : slot_idx;
      nd_wdata  = cmd.load ? req_next_value : (cmd.set_next ? setnext_val : new_nd);
      rem_wdata = cmd.load ? TIME_W'(req_iterations) : new_rem;
   end

   tdt_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SLOTS)) u_nd_ram (
      .clock (clock),
      .we    (nd_we),
      .waddr (wr_addr),
      .wdata (nd_wdata),
      .re    (cmd.issue),
      .raddr (rd_addr_ff),
      .rdata (nd_rdata)
   );

   tdt_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SLOTS)) u_per_ram (
      .clock (clock),
      .we    (per_we),
      .waddr (wr_addr),
      .wdata (req_period),
      .re    (cmd.issue),
      .raddr (rd_addr_ff),
      .rdata (per_rdata)
   );

   tdt_ram #(.WIDTH(TIME_W), .DEPTH(NUM_SLOTS)) u_rem_ram (
      .clock (clock),
      .we    (rem_we),
      .waddr (wr_addr),
      .wdata (rem_wdata),
      .re    (cmd.issue),
      .raddr (rd_addr_ff),
      .rdata (rem_rdata)
   );

   // Mark written entries and load active flags
   always_comb begin
      nd_vld_in  = nd_vld_ff;
      per_vld_in = per_vld_ff;
      rem_vld_in = rem_vld_ff;
      active_in  = active_ff;
      if (nd_we) begin
         nd_vld_in[wr_addr] = 1'b1;
      end
      if (per_we) begin
         per_vld_in[wr_addr] = 1'b1;
      end
      if (rem_we) begin
         rem_vld_in[wr_addr] = 1'b1;
      end
      if (load_ok) begin
         active_in[slot_idx] = req_task_active;
      end
   end

   // Advance the scan pipeline
   always_comb begin
      now_in        = cmd.start ? req_now : now_ff;
      rd_addr_in    = rd_addr_ff;
      eval_idx_in   = eval_idx_ff;
      eval_valid_in = eval_valid_ff;
      if (cmd.start) begin
         rd_addr_in    = IDX_W'(NUM_SLOTS - 1);
         eval_valid_in = 1'b0;
      end else if (cmd.kill) begin
         eval_valid_in = 1'b0;
      end else if (cmd.issue) begin
         rd_addr_in    = rd_addr_ff - 1'b1;
         eval_idx_in   = rd_addr_ff;
         eval_valid_in = 1'b1;
      end else if (cmd.step) begin
         eval_valid_in = 1'b0;
      end
   end

   // Hold the latest dispatch until the next one or the end of the tick
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_slot_in  = pend_slot_ff;
      cnt_in        = cnt_ff;
      if (cmd.start || cmd.flush) begin
         pend_valid_in = 1'b0;
         cnt_in        = '0;
      end else if (cmd.step && fire) begin
         pend_valid_in = 1'b1;
         pend_slot_in  = eval_idx_ff;
         cnt_in        = cnt_ff + 1'b1;
      end
   end

   // Load the output register, drop it once the transfer completes
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_fired_in = rsp_fired_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (push_pend) begin
         rsp_valid_in = 1'b1;
         rsp_fired_in = 1'b1;
         rsp_slot_in  = SLOT_W'(pend_slot_ff);
         rsp_last_in  = 1'b0;
      end else if (cmd.flush) begin
         rsp_valid_in = 1'b1;
         rsp_fired_in = pend_valid_ff;
         rsp_slot_in  = pend_valid_ff ? SLOT_W'(pend_slot_ff) : '0;
         rsp_last_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eval_valid_ff <= 1'b0;
         active_ff     <= '0;
         nd_vld_ff     <= '0;
         per_vld_ff    <= '0;
         rem_vld_ff    <= '0;
         pend_valid_ff <= 1'b0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         eval_valid_ff <= eval_valid_in;
         active_ff     <= active_in;
         nd_vld_ff     <= nd_vld_in;
         per_vld_ff    <= per_vld_in;
         rem_vld_ff    <= rem_vld_in;
         pend_valid_ff <= pend_valid_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff       <= now_in;
      rd_addr_ff   <= rd_addr_in;
      eval_idx_ff  <= eval_idx_in;
      pend_slot_ff <= pend_slot_in;
      rsp_fired_ff <= rsp_fired_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // Status to the controller
   always_comb begin
      sts.last_addr  = (rd_addr_ff == '0);
      sts.eval_valid = eval_valid_ff;
      sts.eval_fire  = fire;
      sts.pend_valid = pend_valid_ff;
      sts.out_free   = !rsp_valid_ff || rsp_ready;
      sts.limit_next = fire && (cnt_ff == CNT_W'(MAX_RESULTS - 1));
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_fired     = rsp_fired_ff;
   assign rsp_task_slot = rsp_slot_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire

@@ hw/rtl/tdt_checker.sv @@
`default_nettype none

module tdt_checker
   import tdt_pkg::*;
(
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic [CMD_W-1:0]  req_command,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic              rsp_fired,
   input wire logic [SLOT_W-1:0] rsp_task_slot,
   input wire logic              rsp_last
);

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_fired, rsp_task_slot, rsp_last}))
      else $error("result changed while stalled");

   // A tick without dispatch is a lone last result with slot zero
   a_idle_tick: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_fired |-> rsp_last && (rsp_task_slot == '0))
      else $error("no-dispatch result malformed");

   // A tick transfer starts a scan that blocks the input
   a_tick_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == CMD_TICK) |=> !req_ready)
      else $error("input ready during scan");

   // Reset leaves no result pending
   a_reset_clear: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind periodic_task_dispatch_timer tdt_checker u_tdt_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .req_command   (req_chan.command),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_fired     (rsp_chan.fired),
   .rsp_task_slot (rsp_chan.task_slot),
   .rsp_last      (rsp_chan.last)
);

`default_nettype wire

@@ test/tb_periodic_task_dispatch_timer.sv @@
module tb_periodic_task_dispatch_timer
   import tdt_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_SLOTS    = DEF_NUM_SLOTS;
   localparam int CLK_PERIOD   = 10;
   localparam int RUN_LIMIT    = 1_000_000;
   localparam int SETTLE_TICKS = 3 * (NUM_SLOTS + 2);
   localparam int MAX_REPORTS  = 10;

   // Codes the block must ignore
   localparam logic [CMD_W-1:0]  CMD_UNUSED  = 2'd3;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [TIME_W-1:0] now;
      logic [SLOT_W-1:0] slot;
      logic              task_active;
      logic [MODE_W-1:0] next_mode;
      logic [TIME_W-1:0] next_value;
      logic [TIME_W-1:0] period;
      logic [TIME_W-1:0] iterations;
   } timer_cmd_type;

   typedef struct packed {
      logic              fired;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } dispatch_type;

   typedef struct {
      timer_cmd_type req;
      bit            fixed;
      dispatch_type  fixed_rsp;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tdt_req_if req_chan ();
   tdt_rsp_if rsp_chan ();

   periodic_task_dispatch_timer #(
      .NUM_SLOTS(NUM_SLOTS)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Shadow copy of the slot tables
   logic              slot_on   [NUM_SLOTS];
   logic [TIME_W-1:0] due_time  [NUM_SLOTS];
   logic [TIME_W-1:0] tick_period [NUM_SLOTS];
   logic [TIME_W-1:0] runs_left [NUM_SLOTS];

   dispatch_type      fresh_dispatches[$];
   dispatch_type      dispatch_q[$];
   logic [TIME_W-1:0] wall_ms;
   int                send_idle_pct;
   int                recv_idle_pct;
   int                mismatches = 0;
   int unsigned       run_cycles = 0;

   // Apply one command to the shadow tables; a tick leaves its dispatches in fresh_dispatches
   function automatic void advance_timer(input timer_cmd_type c);
      logic [TIME_W-1:0] gap;
      int                fires;
      int                s;
      fresh_dispatches.delete();
      fires = 0;
      case (c.command)
         CMD_LOAD: begin
            if (c.slot < NUM_SLOTS) begin
               slot_on[c.slot]     = c.task_active;
               due_time[c.slot]    = c.next_value;
               tick_period[c.slot] = c.period;
               runs_left[c.slot]   = c.iterations;
            end
         end
         CMD_SET_NEXT: begin
            if (c.slot < NUM_SLOTS) begin
               case (c.next_mode)
                  MODE_NOW:    due_time[c.slot] = c.now;
                  MODE_NEVER:  due_time[c.slot] = NEVER_TIME;
                  MODE_OFFSET: due_time[c.slot] = (c.next_value == NEVER_TIME) ?
                                                  NEVER_TIME : c.now + c.next_value;
                  default: ;
               endcase
            end
         end
         CMD_TICK: begin
            // scan from the top slot down, stop once the result limit is reached
            for (s = NUM_SLOTS - 1; s >= 0 && fires < MAX_RESULTS; s--) begin
               if (slot_on[s] && due_time[s] != NEVER_TIME) begin
                  if (runs_left[s] == '0) begin
                     due_time[s]  = NEVER_TIME;
                     runs_left[s] = UNLIMITED;
                  end else begin
                     gap = due_time[s] - c.now;
                     if (gap == '0 || gap[TIME_W-1]) begin
                        due_time[s] = (tick_period[s] == '0) ? NEVER_TIME
                                                             : due_time[s] + tick_period[s];
                        if (!runs_left[s][TIME_W-1])
                           runs_left[s] = runs_left[s] - 1;
                        fresh_dispatches.push_back('{1'b1, SLOT_W'(s), 1'b0});
                        fires++;
                     end
                  end
               end
            end
            if (fires == 0)
               fresh_dispatches.push_back('{1'b0, '0, 1'b1});
            else
               fresh_dispatches[fresh_dispatches.size() - 1].last = 1'b1;
         end
         default: ;
      endcase
   endfunction

   function automatic void note_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch at %0t: %s", $time, what);
   endfunction

   // Stimulus table rows
   function automatic script_row_type load_row(input logic [SLOT_W-1:0] sl, input logic act,
                                               input logic [TIME_W-1:0] due, per, runs);
      script_row_type r;
      r.req.command     = CMD_LOAD;
      r.req.now         = $urandom;
      r.req.slot        = sl;
      r.req.task_active = act;
      r.req.next_mode   = MODE_W'($urandom_range(0, 3));
      r.req.next_value  = due;
      r.req.period      = per;
      r.req.iterations  = runs;
      r.fixed           = 1'b0;
      r.fixed_rsp       = '0;
      return r;
   endfunction

   function automatic script_row_type next_row(input logic [SLOT_W-1:0] sl,
                                               input logic [MODE_W-1:0] mode,
                                               input logic [TIME_W-1:0] now, offset);
      script_row_type r;
      r = load_row(sl, 1'($urandom_range(0, 1)), offset, $urandom, $urandom);
      r.req.command   = CMD_SET_NEXT;
      r.req.next_mode = mode;
      r.req.now       = now;
      return r;
   endfunction

   function automatic script_row_type tick_row(input logic [TIME_W-1:0] now, input bit fixed,
                                               input logic fired,
                                               input logic [SLOT_W-1:0] sl);
      script_row_type r;
      r = load_row(SLOT_W'($urandom), 1'($urandom_range(0, 1)), $urandom, $urandom,
                   $urandom);
      r.req.command   = CMD_TICK;
      r.req.now       = now;
      r.fixed         = fixed;
      r.fixed_rsp     = '{fired, sl, 1'b1};
      return r;
   endfunction

   // Random command along a running millisecond timeline
   function automatic timer_cmd_type random_cmd();
      timer_cmd_type c;
      int            pick;
      int            mode_pick;
      c.command     = CMD_TICK;
      c.now         = $urandom;
      c.slot        = SLOT_W'($urandom);
      c.task_active = ($urandom_range(0, 9) != 0);
      c.next_mode   = MODE_W'($urandom_range(0, 3));
      c.next_value  = $urandom;
      c.period      = $urandom;
      c.iterations  = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
         if ($urandom_range(0, 49) == 0)
            wall_ms = $urandom;
         else
            wall_ms = wall_ms + $urandom_range(0, 6);
         c.now = wall_ms;
      end else if (pick < 75) begin
         c.command = CMD_LOAD;
         case ($urandom_range(0, 9))
            0:       c.next_value = NEVER_TIME;
            1:       c.next_value = $urandom;
            default: c.next_value = wall_ms + $urandom_range(0, 25);
         endcase
         case ($urandom_range(0, 9))
            0:       c.period = '0;
            1:       c.period = $urandom;
            default: c.period = $urandom_range(1, 12);
         endcase
         case ($urandom_range(0, 9))
            0, 1:    c.iterations = UNLIMITED;
            2:       c.iterations = $urandom;
            default: c.iterations = $urandom_range(0, 4);
         endcase
      end else if (pick < 93) begin
         c.command = CMD_SET_NEXT;
         c.now     = wall_ms;
         mode_pick = $urandom_range(0, 9);
         if (mode_pick == 0)
            c.next_mode = MODE_UNUSED;
         else if (mode_pick < 4)
            c.next_mode = MODE_NOW;
         else if (mode_pick < 6)
            c.next_mode = MODE_NEVER;
         else
            c.next_mode = MODE_OFFSET;
         case ($urandom_range(0, 9))
            0:       c.next_value = NEVER_TIME;
            1:       c.next_value = $urandom;
            default: c.next_value = $urandom_range(0, 20);
         endcase
      end else begin
         c.command = CMD_UNUSED;
      end
      return c;
   endfunction

   // Present one command, hold it until the transfer, then record what it should cause
   task automatic send_item(input timer_cmd_type c, input bit fixed,
                            input dispatch_type fixed_rsp);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.command     <= c.command;
      req_chan.now         <= c.now;
      req_chan.slot        <= c.slot;
      req_chan.task_active <= c.task_active;
      req_chan.next_mode   <= c.next_mode;
      req_chan.next_value  <= c.next_value;
      req_chan.period      <= c.period;
      req_chan.iterations  <= c.iterations;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      advance_timer(c);
      if (fixed)
         dispatch_q.push_back(fixed_rsp);
      else
         foreach (fresh_dispatches[k]) dispatch_q.push_back(fresh_dispatches[k]);
   endtask

   // Hold the request side until every expected dispatch has come back
   task automatic wait_for_dispatches();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (dispatch_q.size() != 0) @(negedge clock);
   endtask

   // Load every slot close to the current time, then tick so that most fire at once
   task automatic arm_all_slots();
      script_row_type r;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         r = load_row(SLOT_W'(s), 1'b1, wall_ms - $urandom_range(0, 3),
                      $urandom_range(0, 5), $urandom_range(0, 1) ? UNLIMITED
                                                                 : $urandom_range(1, 3));
         send_item(r.req, 1'b0, '0);
      end
      r = tick_row(wall_ms, 1'b0, 1'b0, '0);
      send_item(r.req, 1'b0, '0);
   endtask

   task automatic run_phase(input int sender_pct, input int receiver_pct, input int items);
      timer_cmd_type c;
      int            taken;
      send_idle_pct = sender_pct;
      recv_idle_pct = receiver_pct;
      arm_all_slots();
      taken = 0;
      while (taken < items) begin
         c = random_cmd();
         send_item(c, 1'b0, '0);
         if (c.command != CMD_UNUSED)
            taken++;
      end
      wait_for_dispatches();
   endtask

   // Receiver: stall at random
   always @(negedge clock)
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

   // Compare each result transfer with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin : check_result
         dispatch_type want;
         if (dispatch_q.size() == 0) begin
            note_mismatch($sformatf("unexpected result fired %0b slot %0d last %0b",
                                    rsp_chan.fired, rsp_chan.task_slot, rsp_chan.last));
         end else begin
            want = dispatch_q.pop_front();
            if (rsp_chan.fired !== want.fired)
               note_mismatch($sformatf("fired expected %0b got %0b",
                                       want.fired, rsp_chan.fired));
            if (rsp_chan.task_slot !== want.slot)
               note_mismatch($sformatf("task_slot expected %0d got %0d",
                                       want.slot, rsp_chan.task_slot));
            if (rsp_chan.last !== want.last)
               note_mismatch($sformatf("last expected %0b got %0b",
                                       want.last, rsp_chan.last));
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      run_cycles <= run_cycles + 1;
      if (run_cycles >= RUN_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      script_row_type script[$];
      script_row_type row;

      req_chan.valid       = 1'b0;
      req_chan.command     = CMD_TICK;
      req_chan.now         = '0;
      req_chan.slot        = '0;
      req_chan.task_active = 1'b0;
      req_chan.next_mode   = MODE_NOW;
      req_chan.next_value  = '0;
      req_chan.period      = '0;
      req_chan.iterations  = '0;
      wall_ms              = 32'h0000_1000;
      send_idle_pct        = 14;
      recv_idle_pct        = 74;
      for (int s = 0; s < NUM_SLOTS; s++) begin
         slot_on[s]     = 1'b0;
         due_time[s]    = NEVER_TIME;
         tick_period[s] = '0;
         runs_left[s]   = UNLIMITED;
      end

      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // Directed table
      script.push_back(tick_row(32'd0, 1'b1, 1'b0, 4'd0));
      script.push_back(load_row(4'd15, 1'b1, 32'd10, 32'd0, UNLIMITED));
      script.push_back(tick_row(32'd9, 1'b1, 1'b0, 4'd0));
      script.push_back(tick_row(32'd10, 1'b1, 1'b1, 4'd15));
      script.push_back(tick_row(32'd11, 1'b1, 1'b0, 4'd0));
      // period lands the next due time exactly on never
      script.push_back(load_row(4'd0, 1'b1, 32'hFFFF_FFF0, 32'h0000_000F, 32'd2));
      script.push_back(tick_row(32'hFFFF_FFF0, 1'b1, 1'b1, 4'd0));
      script.push_back(tick_row(32'd5, 1'b1, 1'b0, 4'd0));
      // an offset of never disarms
      script.push_back(next_row(4'd0, MODE_OFFSET, 32'd3, NEVER_TIME));
      script.push_back(tick_row(32'h0000_1000, 1'b1, 1'b0, 4'd0));
      script.push_back(next_row(4'd0, MODE_NOW, 32'h20, $urandom));
      script.push_back(tick_row(32'h20, 1'b1, 1'b1, 4'd0));
      // count used up: disarm without dispatch
      script.push_back(tick_row(32'h40, 1'b1, 1'b0, 4'd0));
      script.push_back(tick_row(32'h40, 1'b1, 1'b0, 4'd0));
      // half-range difference counts as due; negative count never decrements
      script.push_back(load_row(4'd7, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000));
      script.push_back(tick_row(32'd0, 1'b1, 1'b1, 4'd7));
      script.push_back(tick_row(32'h7FFF_FFFF, 1'b0, 1'b0, 4'd0));
      // removing a task still stores the fields
      script.push_back(load_row(4'd7, 1'b0, 32'd0, 32'd5, 32'd3));
      script.push_back(tick_row(32'h100, 1'b1, 1'b0, 4'd0));
      script.push_back(load_row(4'd3, 1'b1, 32'h10, 32'd0, UNLIMITED));
      // unknown next mode and unknown command change nothing
      script.push_back(next_row(4'd3, MODE_UNUSED, 32'd0, 32'd0));
      row = next_row(4'd3, MODE_NOW, 32'd0, 32'd0);
      row.req.command = CMD_UNUSED;
      script.push_back(row);
      script.push_back(tick_row(32'h0F, 1'b1, 1'b0, 4'd0));
      // offset wraps past zero
      script.push_back(next_row(4'd3, MODE_OFFSET, 32'hFFFF_FFF8, 32'h18));
      script.push_back(tick_row(32'h10, 1'b1, 1'b1, 4'd3));

      foreach (script[i]) send_item(script[i].req, script[i].fixed, script[i].fixed_rsp);
      wait_for_dispatches();

      // Random traffic under three idling mixes
      run_phase(14, 74, 42);
      run_phase(74, 14, 42);
      run_phase(0, 0, 42);

      repeat (SETTLE_TICKS) @(posedge clock);
      if (mismatches == 0 && dispatch_q.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/tdt_pkg.sv
hw/rtl/tdt_if.sv
hw/rtl/tdt_ram.sv
hw/rtl/tdt_ctrl.sv
hw/rtl/tdt_dpath.sv
hw/rtl/periodic_task_dispatch_timer.sv
hw/rtl/tdt_checker.sv
test/tb_periodic_task_dispatch_timer.sv
